// File: hdl/rmc_pkg.sv
// rmc_pkg: shared types and constants of the maze carver.
// No dependencies; used by random_maze_carver_unit.
`default_nettype none

package rmc_pkg;

  localparam int unsigned CoordW        = 6;
  localparam int unsigned RndW          = 16;
  localparam int unsigned LeftW         = 11;
  localparam int unsigned PushW         = 3;
  localparam int unsigned MaxSide       = 63;
  localparam int unsigned FrontierDepth = 1024;
  localparam int unsigned MinSide       = 5;
  localparam int unsigned StepDist      = 2;
  localparam logic [CoordW-1:0] SideReset = 6'd63;

  // function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // register indexes
  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  // neighbor order
  localparam logic [1:0] DIR_W = 2'd0;
  localparam logic [1:0] DIR_N = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_S = 2'd3;

  typedef struct packed {
    logic            func;
    logic [RndW-1:0] random_value;
  } cmd_t;

  typedef struct packed {
    logic              carved;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [CoordW-1:0] wall_x;
    logic [CoordW-1:0] wall_y;
    logic [PushW-1:0]  pushed_count;
    logic [LeftW-1:0]  frontier_left;
    logic              finished;
    logic              bad_size;
  } res_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } ent_t;

endpackage

`default_nettype wire

// File: hdl/rmc_ram.sv
// rmc_ram: simple dual-port RAM, one write and one registered read port.
// No dependencies; used for the wall map and the frontier list.
`default_nettype none

module rmc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/random_maze_carver_unit.sv
// random_maze_carver_unit: randomized Prim maze carver, top level.
// Depends on rmc_pkg and rmc_ram.
//
// channel   dir  signals                          handshake
// command   in   start, cmd_i                     taken when start & !busy
// result    out  res_valid_o, res_o               one-cycle strobe, no stall
// config    in   cfg_valid_i, cfg_index_i, data   taken when valid & ready
//
// Refused start or step on an empty frontier: result in the cycle after accept.
// Good start: sweep of all (MAX_SIDE+1)^2 map cells (4096 at default), then the seed.
// Step: index pick, entry read, ordered shift of the later words for removal,
// midpoint and report, with a check of each neighbor in turn, plus a
// wall-map read for each neighbor that is in range.
// After reset the same map sweep runs with busy high.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module random_maze_carver_unit #(
  parameter int unsigned MAX_SIDE       = rmc_pkg::MaxSide,
  parameter int unsigned FRONTIER_DEPTH = rmc_pkg::FrontierDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire rmc_pkg::cmd_t              cmd_i,
  output logic                            res_valid_o,
  output rmc_pkg::res_t                   res_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [0:0]                 cfg_index_i,
  input  wire logic [rmc_pkg::CoordW-1:0] cfg_data_i
);

  localparam int unsigned CW     = rmc_pkg::CoordW;
  localparam int unsigned Stride = MAX_SIDE + 1;
  localparam int unsigned Cells  = Stride * Stride;
  localparam int unsigned MW     = $clog2(Cells);
  localparam int unsigned FW     = $clog2(FRONTIER_DEPTH + 1);
  localparam int unsigned AW     = $clog2(FRONTIER_DEPTH);
  localparam int unsigned EW     = $bits(rmc_pkg::ent_t);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_SEED  = 10'b0000000100,
    S_MUL   = 10'b0000001000,
    S_RDE   = 10'b0000010000,
    S_GETE  = 10'b0000100000,
    S_SHIFT = 10'b0001000000,
    S_MID   = 10'b0010000000,
    S_NRD   = 10'b0100000000,
    S_NCHK  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [MW-1:0] clr_q, clr_d;
  logic clr_start_q, clr_start_d;
  logic [CW-1:0] w_q, h_q;
  logic [rmc_pkg::RndW-1:0] rnd_q, rnd_d;
  logic [FW-1:0] size_q, size_d, sh_q, sh_d;
  logic [AW-1:0] idx_q, idx_d, wadr_q, wadr_d;
  logic wpend_q, wpend_d;
  rmc_pkg::ent_t ent_q, ent_d;
  logic [1:0] dir_q, dir_d;
  logic [rmc_pkg::PushW-1:0] push_q, push_d;
  rmc_pkg::res_t res_q, res_d;
  logic res_valid_q, res_valid_d;

  // memory ports
  logic map_we, map_wdata, map_re, map_rdata;
  logic [MW-1:0] map_waddr, map_raddr;
  logic fr_we, fr_re;
  logic [AW-1:0] fr_waddr, fr_raddr;
  logic [EW-1:0] fr_wdata, fr_rdata;

  logic [rmc_pkg::RndW+FW-1:0] prod;
  logic [CW:0] mx, my, nx, ny;
  logic ncond, ninb, mid_inb, bad, fin;

  function automatic logic [MW-1:0] map_addr(input logic [CW:0] x, input logic [CW:0] y);
    map_addr = MW'(32'(y) * Stride + 32'(x));
  endfunction

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= rmc_pkg::SideReset;
      h_q <= rmc_pkg::SideReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rmc_pkg::REG_WIDTH:  w_q <= cfg_data_i;
        rmc_pkg::REG_HEIGHT: h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rmc_ram #(.Width(1), .Depth(Cells)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  rmc_ram #(.Width(EW), .Depth(FRONTIER_DEPTH)) u_front (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .re_i    (fr_re),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // midpoint toward the parent and the neighbor under test
  always_comb begin
    mx      = ((CW+1)'(ent_q.x) + (CW+1)'(ent_q.px)) >> 1;
    my      = ((CW+1)'(ent_q.y) + (CW+1)'(ent_q.py)) >> 1;
    mid_inb = (32'(mx) < Stride) && (32'(my) < Stride);
    nx      = (CW+1)'(ent_q.x);
    ny      = (CW+1)'(ent_q.y);
    ncond   = 1'b0;
    case (dir_q)
      rmc_pkg::DIR_W: begin
        ncond = ent_q.x > CW'(1);
        nx    = (CW+1)'(ent_q.x) - (CW+1)'(rmc_pkg::StepDist);
      end
      rmc_pkg::DIR_N: begin
        ncond = ent_q.y > CW'(1);
        ny    = (CW+1)'(ent_q.y) - (CW+1)'(rmc_pkg::StepDist);
      end
      rmc_pkg::DIR_E: begin
        nx    = (CW+1)'(ent_q.x) + (CW+1)'(rmc_pkg::StepDist);
        ncond = nx < (CW+1)'(w_q);
      end
      rmc_pkg::DIR_S: begin
        ny    = (CW+1)'(ent_q.y) + (CW+1)'(rmc_pkg::StepDist);
        ncond = ny < (CW+1)'(h_q);
      end
      default: ;
    endcase
    ninb = (32'(nx) < Stride) && (32'(ny) < Stride);
    bad  = !w_q[0] || !h_q[0] || (32'(w_q) < rmc_pkg::MinSide) ||
           (32'(h_q) < rmc_pkg::MinSide) || (32'(w_q) > MAX_SIDE) ||
           (32'(h_q) > MAX_SIDE);
  end

  assign prod = rnd_q * size_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    clr_start_d = clr_start_q;
    rnd_d       = rnd_q;
    size_d      = size_q;
    sh_d        = sh_q;
    idx_d       = idx_q;
    wadr_d      = wadr_q;
    wpend_d     = 1'b0;
    ent_d       = ent_q;
    dir_d       = dir_q;
    push_d      = push_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    fin         = 1'b0;
    map_we      = 1'b0;
    map_waddr   = clr_q;
    map_wdata   = 1'b1;
    map_re      = 1'b0;
    map_raddr   = map_addr(nx, ny);
    fr_we       = 1'b0;
    fr_waddr    = wadr_q;
    fr_wdata    = fr_rdata;
    fr_re       = 1'b0;
    fr_raddr    = sh_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (start) begin
          rnd_d = cmd_i.random_value;
          res_d = '0;
          if (cmd_i.func == rmc_pkg::FUNC_START) begin
            if (bad) begin
              res_d.bad_size      = 1'b1;
              res_d.frontier_left = rmc_pkg::LeftW'(size_q);
              res_d.finished      = (size_q == '0);
              res_valid_d         = 1'b1;
            end else begin
              clr_d       = '0;
              clr_start_d = 1'b1;
              state_d     = S_CLEAR;
            end
          end else if (size_q == '0) begin
            res_d.finished = 1'b1;
            res_valid_d    = 1'b1;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      // walls everywhere, one cell a cycle
      S_CLEAR: begin
        map_we = 1'b1;
        clr_d  = clr_q + MW'(1);
        if (32'(clr_q) == Cells - 1) begin
          state_d = clr_start_q ? S_SEED : S_IDLE;
        end
      end
      // open (1,1) and make it the only frontier word
      S_SEED: begin
        map_we    = 1'b1;
        map_waddr = map_addr((CW+1)'(1), (CW+1)'(1));
        map_wdata = 1'b0;
        fr_we     = 1'b1;
        fr_waddr  = '0;
        fr_wdata  = {CW'(1), CW'(1), CW'(1), CW'(1)};
        size_d    = FW'(1);
        res_d.frontier_left = rmc_pkg::LeftW'(1);
        res_valid_d = 1'b1;
        state_d   = S_IDLE;
      end
      S_MUL: begin
        idx_d   = prod[rmc_pkg::RndW +: AW];
        state_d = S_RDE;
      end
      S_RDE: begin
        fr_re    = 1'b1;
        fr_raddr = idx_q;
        state_d  = S_GETE;
      end
      S_GETE: begin
        ent_d   = fr_rdata;
        sh_d    = FW'(idx_q) + FW'(1);
        state_d = S_SHIFT;
      end
      // ordered removal: read entry k, write it to k-1 in the next cycle
      S_SHIFT: begin
        fr_we = wpend_q;
        if (sh_q < size_q) begin
          fr_re   = 1'b1;
          wpend_d = 1'b1;
          wadr_d  = sh_q[AW-1:0] - AW'(1);
          sh_d    = sh_q + FW'(1);
        end else if (!wpend_q) begin
          size_d  = size_q - FW'(1);
          state_d = S_MID;
        end
      end
      S_MID: begin
        map_we       = mid_inb;
        map_waddr    = map_addr(mx, my);
        map_wdata    = 1'b0;
        res_d.carved = 1'b1;
        res_d.cell_x = ent_q.x;
        res_d.cell_y = ent_q.y;
        res_d.wall_x = mx[CW-1:0];
        res_d.wall_y = my[CW-1:0];
        dir_d        = rmc_pkg::DIR_W;
        push_d       = '0;
        state_d      = S_NRD;
      end
      S_NRD: begin
        if (ncond && ninb) begin
          map_re  = 1'b1;
          state_d = S_NCHK;
        end else if (dir_q == rmc_pkg::DIR_S) begin
          fin = 1'b1;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      S_NCHK: begin
        if (map_rdata && (size_q < FW'(FRONTIER_DEPTH))) begin
          map_we    = 1'b1;
          map_waddr = map_addr(nx, ny);
          map_wdata = 1'b0;
          fr_we     = 1'b1;
          fr_waddr  = size_q[AW-1:0];
          fr_wdata  = {nx[CW-1:0], ny[CW-1:0], ent_q.x, ent_q.y};
          size_d    = size_q + FW'(1);
          push_d    = push_q + rmc_pkg::PushW'(1);
        end
        if (dir_q == rmc_pkg::DIR_S) begin
          fin = 1'b1;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = S_NRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // step done: report with the updated count
    if (fin) begin
      res_d.pushed_count  = push_d;
      res_d.frontier_left = rmc_pkg::LeftW'(size_d);
      res_d.finished      = (size_d == '0);
      res_valid_d         = 1'b1;
      state_d             = S_IDLE;
    end
  end

  // control registers; reset starts a map sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      clr_start_q <= 1'b0;
      size_q      <= '0;
      sh_q        <= '0;
      wpend_q     <= 1'b0;
      dir_q       <= '0;
      push_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_start_q <= clr_start_d;
      size_q      <= size_d;
      sh_q        <= sh_d;
      wpend_q     <= wpend_d;
      dir_q       <= dir_d;
      push_q      <= push_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rnd_q  <= rnd_d;
    idx_q  <= idx_d;
    wadr_q <= wadr_d;
    ent_q  <= ent_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire
